// ----- src/tow_pkg.sv -----
// Package for the tank overflow watch: sizes, codes and the cell interface types.
// Used by tow_cell and tank_overflow_watch; depends on nothing.
package tow_pkg;

  // Number of watched tanks, one cell each
  localparam int TANKS = 4;
  localparam int IDX_W = (TANKS > 1) ? $clog2(TANKS) : 1;

  // Field widths
  localparam int LVL_W  = 16;
  localparam int TMR_W  = 8;
  localparam int KIND_W = 2;
  localparam int TNUM_W = 2;

  // Configuration register indexes and reset values
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_TICKS     = 1'b1;
  localparam logic [LVL_W-1:0] THRESHOLD_RST = 16'd7500;
  localparam logic [TMR_W-1:0] TICKS_RST     = 8'(3 * 10);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READING = 2'd2;

  // Result event codes
  localparam logic EV_REQUEST = 1'b0;
  localparam logic EV_ALARM   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_REQ
  } state_e;

  // Command from the controller to one cell
  typedef struct packed {
    logic             arm;
    logic             rd;
    logic             inject;
    logic [LVL_W-1:0] lvl;
    logic [LVL_W-1:0] thr;
    logic [TMR_W-1:0] ticks;
  } cell_cmd_t;

  // Status from one cell to the controller
  typedef struct packed {
    logic hit;
    logic alarm;
  } cell_sts_t;

endpackage

// ----- src/tow_cell.sv -----
// One tank cell: holds the tank's watch timer and last level, and passes the
// scan token to its neighbor. Depends on tow_pkg.
module tow_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tow_pkg::cell_cmd_t cmd_i,
  input  logic              tok_i,
  output logic              tok_o,
  output tow_pkg::cell_sts_t sts_o
);
  import tow_pkg::*;

  logic [TMR_W-1:0] timer_q, timer_d;
  logic [LVL_W-1:0] level_q;
  logic             tok_q, tok_d;
  logic             hit, rise, alarm;

  // Check the token against this tank and evaluate a reading
  always_comb begin
    hit   = tok_q && (timer_q != '0);
    tok_o = tok_q && (timer_q == '0);
    rise  = cmd_i.lvl > level_q;
    alarm = cmd_i.rd && rise && (cmd_i.lvl >= cmd_i.thr);
    tok_d = cmd_i.inject | tok_i;
    sts_o.hit   = hit;
    sts_o.alarm = alarm;
  end

  // Arm, re-arm, disarm or count down the timer
  always_comb begin
    timer_d = timer_q;
    if (cmd_i.arm) begin
      timer_d = cmd_i.ticks;
    end else if (cmd_i.rd && rise) begin
      timer_d = alarm ? '0 : cmd_i.ticks;
    end else if (hit) begin
      timer_d = timer_q - TMR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
      tok_q   <= 1'b0;
    end else begin
      timer_q <= timer_d;
      tok_q   <= tok_d;
    end
  end

  // Store the level on add and on a reading for this tank
  always_ff @(posedge clk_i) begin
    if (cmd_i.arm || cmd_i.rd) begin
      level_q <= cmd_i.lvl;
    end
  end

endmodule

// ----- src/tank_overflow_watch.sv -----
// Top level of the tank overflow watch: controller, configuration registers
// and the row of tow_cell instances. Depends on tow_pkg and tow_cell.
//
// channel   direction  handshake              payload
// command   in         start_i & !busy_o      kind_i, tank_index_i, level_i
// result    out        strobe_o (one cycle)   event_res_o, tank_number_o, last_o
// config    in         cfg_we_i               cfg_addr_i, cfg_data_i
//
// An add item needs no scan; a tick with no read outstanding, or a reading
// for the outstanding tank other than the last, starts a scan that moves the
// token one cell per cycle. A reading scans only the cells past the read tank.
// Results appear in the cycle after the decision, in registered outputs.
// Reset clears all timers and the outstanding read; stored levels are kept.
// The receiver cannot stall.
module tank_overflow_watch (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [tow_pkg::KIND_W-1:0]  kind_i,
  input  logic [1:0]                  tank_index_i,
  input  logic [tow_pkg::LVL_W-1:0]   level_i,
  output logic                        strobe_o,
  output logic                        event_res_o,
  output logic [tow_pkg::TNUM_W-1:0]  tank_number_o,
  output logic                        last_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [tow_pkg::LVL_W-1:0]   cfg_data_i
);
  import tow_pkg::*;

  state_e             state_q, state_d;
  logic [LVL_W-1:0]   thr_q;
  logic [TMR_W-1:0]   ticks_q;
  logic               rvalid_q, rvalid_d;
  logic [IDX_W-1:0]   rtank_q, rtank_d;
  logic [IDX_W-1:0]   atank_q, atank_d;
  logic               apend_q, apend_d;
  logic               strobe_q, strobe_d;
  logic               ev_q, ev_d;
  logic [TNUM_W-1:0]  tnum_q, tnum_d;
  logic               last_q, last_d;

  cell_cmd_t          cmd [TANKS];
  cell_sts_t          sts [TANKS];
  logic [TANKS:0]     tok_chain;
  logic [TANKS-1:0]   arm, rd, inject, hit_vec, alarm_vec;
  logic               accept, any_hit, miss, any_alarm;
  logic [IDX_W-1:0]   hit_idx;
  int                 next_tank;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RST;
      ticks_q <= TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_THRESHOLD: thr_q   <= cfg_data_i;
        REG_TICKS:     ticks_q <= cfg_data_i[TMR_W-1:0];
        default:       thr_q   <= thr_q;
      endcase
    end
  end

  // Row of cells with the token handed from each cell to the next
  assign tok_chain[0] = 1'b0;
  for (genvar g = 0; g < TANKS; g++) begin : g_cell
    assign cmd[g].arm    = arm[g];
    assign cmd[g].rd     = rd[g];
    assign cmd[g].inject = inject[g];
    assign cmd[g].lvl    = level_i;
    assign cmd[g].thr    = thr_q;
    assign cmd[g].ticks  = ticks_q;
    assign hit_vec[g]    = sts[g].hit;
    assign alarm_vec[g]  = sts[g].alarm;

    tow_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[g]),
      .tok_i  (tok_chain[g]),
      .tok_o  (tok_chain[g+1]),
      .sts_o  (sts[g])
    );
  end

  assign any_hit   = |hit_vec;
  assign any_alarm = |alarm_vec;
  assign miss      = tok_chain[TANKS];

  // Encode the cell that claimed the token
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TANKS; i++) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Decode per-cell commands for the accepted item
  always_comb begin
    next_tank = int'(rtank_q) + 1;
    for (int i = 0; i < TANKS; i++) begin
      arm[i]    = accept && (kind_i == KIND_ADD) && (int'(tank_index_i) == i);
      rd[i]     = accept && (kind_i == KIND_READING) && rvalid_q && (int'(rtank_q) == i);
      inject[i] = accept && (((kind_i == KIND_TICK) && !rvalid_q && (i == 0)) ||
                             ((kind_i == KIND_READING) && rvalid_q && (i == next_tank)));
    end
  end

  // Next state and result selection
  always_comb begin
    state_d  = state_q;
    rvalid_d = rvalid_q;
    rtank_d  = rtank_q;
    atank_d  = atank_q;
    apend_d  = apend_q;
    strobe_d = 1'b0;
    ev_d     = EV_REQUEST;
    tnum_d   = tnum_q;
    last_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_TICK: begin
              if (!rvalid_q) begin
                apend_d = 1'b0;
                state_d = ST_SCAN;
              end
            end
            KIND_READING: begin
              if (rvalid_q) begin
                rvalid_d = 1'b0;
                apend_d  = any_alarm;
                atank_d  = rtank_q;
                if (next_tank < TANKS) begin
                  state_d = ST_SCAN;
                end else if (any_alarm) begin
                  // Last tank: no scan follows, the alarm ends the item
                  strobe_d = 1'b1;
                  ev_d     = EV_ALARM;
                  tnum_d   = TNUM_W'(rtank_q);
                  last_d   = 1'b1;
                end
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        rvalid_d = 1'b0;
        if (any_hit) begin
          rvalid_d = 1'b1;
          rtank_d  = hit_idx;
          strobe_d = 1'b1;
          if (apend_q) begin
            ev_d    = EV_ALARM;
            tnum_d  = TNUM_W'(atank_q);
            state_d = ST_EMIT_REQ;
          end else begin
            ev_d    = EV_REQUEST;
            tnum_d  = TNUM_W'(hit_idx);
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (miss) begin
          if (apend_q) begin
            strobe_d = 1'b1;
            ev_d     = EV_ALARM;
            tnum_d   = TNUM_W'(atank_q);
            last_d   = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_REQ: begin
        strobe_d = 1'b1;
        ev_d     = EV_REQUEST;
        tnum_d   = TNUM_W'(rtank_q);
        last_d   = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rvalid_q <= 1'b0;
      apend_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rvalid_d;
      apend_q  <= apend_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rtank_q <= rtank_d;
    atank_q <= atank_d;
    ev_q    <= ev_d;
    tnum_q  <= tnum_d;
    last_q  <= last_d;
  end

  assign strobe_o      = strobe_q;
  assign event_res_o   = ev_q;
  assign tank_number_o = tnum_q;
  assign last_o        = last_q;

  // Only one cell can claim the token at a time
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one cell claimed the scan token");

  // No read is outstanding while a scan runs
  a_scan_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !rvalid_q)
    else $error("read outstanding during scan");

  // The request cycle always follows an alarm that is not last
  a_alarm_before_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_REQ) |-> (strobe_q && (ev_q == EV_ALARM) && !last_q))
    else $error("pending request without a preceding alarm");

endmodule
